>>> hw/rtl/sqg_pkg.sv
`default_nettype none

package sqg_pkg;

  // Width of the consecutive pass and fail counters
  localparam int RUN_COUNT_BITS = 8;
  localparam int WIN_COUNT_BITS = 8;
  localparam int RUN_CMP_BITS =
    (RUN_COUNT_BITS > WIN_COUNT_BITS) ? RUN_COUNT_BITS : WIN_COUNT_BITS;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_CLIPPING = 3'd0;
  localparam logic [2:0] REG_MIN_SNR      = 3'd1;
  localparam logic [2:0] REG_SCORE_THR    = 3'd2;
  localparam logic [2:0] REG_MAX_SILENCE  = 3'd3;
  localparam logic [2:0] REG_OK_WINDOWS   = 3'd4;
  localparam logic [2:0] REG_BAD_WINDOWS  = 3'd5;

  // Fixed-point constants: ratios Q1.16, dB Q8.8, score kept as points * 65536
  localparam logic [16:0] FLAT_OFFSET = 17'd19661;    // 0.3
  localparam logic [16:0] FLAT_SPAN   = 17'd45875;    // 0.7
  localparam logic [16:0] LOSS_SPAN   = 17'd1280;     // 5 percent
  localparam logic [16:0] JIT_SPAN    = 17'd800;      // 50 ms
  localparam logic [16:0] FRAC_ONE    = 17'd65536;
  localparam logic [16:0] SNR_FRAC_MAX = 17'd98304;   // 1.5
  localparam logic [22:0] SCORE_FULL  = 23'd6553600;  // 100 points
  localparam logic signed [16:0] LEVEL_KNEE = -17'sd12800;  // -50 dB
  localparam logic [16:0] LEVEL_DIFF_SAT = 17'd10240;
  localparam logic [20:0] LEVEL_PEN_MAX = 21'd1310720;     // 20 points
  localparam logic [14:0] SCORE_MAX   = 15'd25600;

  // Reciprocals of the constant spans, exact below the span:
  // flatness (n * FLAT_RECIP) >> 30, loss and jitter (n * RECIP) >> 13
  localparam logic [30:0] FLAT_RECIP = 31'(((64'd1 << 46) + 64'd45874) / 64'd45875);
  localparam logic [18:0] LOSS_RECIP = 19'(((64'd1 << 21) + 64'd4) / 64'd5);
  localparam logic [19:0] JIT_RECIP  = 20'(((64'd1 << 24) + 64'd24) / 64'd25);

  typedef struct packed {
    logic [16:0] max_clipping;
    logic [14:0] min_snr;
    logic [14:0] ready_score_threshold;
    logic [16:0] max_silence;
    logic [WIN_COUNT_BITS-1:0] ok_windows_needed;
    logic [WIN_COUNT_BITS-1:0] bad_windows_needed;
  } cfg_t;

  // One classified window as it waits between front and back
  typedef struct packed {
    logic [16:0] clip_num;
    logic [16:0] snr_num;
    logic [16:0] flat_num;
    logic [14:0] loss_num;
    logic [15:0] jit_num;
    logic [20:0] level_pen;
    logic        gate_ok;
  } win_t;

endpackage

`default_nettype wire

>>> hw/rtl/sqg_div.sv
`default_nettype none

// Restoring divider: quot = floor(num * 65536 / den), 2.0 and above reported as 2.0
module sqg_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [16:0] num,
  input  wire logic [16:0] den,
  output logic             busy,
  output logic [17:0]      quot
);

  logic [16:0] rem;
  logic [15:0] frac;
  logic        ibit;
  logic        sat;
  logic [3:0]  cnt;
  logic [17:0] rem2;
  logic [17:0] rem_sub;
  logic        step_ge;
  logic        sat_in;
  logic        ge_in;

  always_comb begin
    rem2    = {rem, 1'b0};
    step_ge = rem2 >= {1'b0, den};
    rem_sub = rem2 - {1'b0, den};
    sat_in  = {1'b0, num} >= {den, 1'b0};
    ge_in   = num >= den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !sat_in;
    end else if (busy && cnt == 4'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat  <= sat_in;
      ibit <= ge_in;
      rem  <= ge_in ? num - den : num;
      frac <= '0;
      cnt  <= 4'd15;
    end else if (busy) begin
      rem  <= step_ge ? rem_sub[16:0] : rem2[16:0];
      frac <= {frac[14:0], step_ge};
      cnt  <= cnt - 4'd1;
    end
  end

  assign quot = sat ? 18'h20000 : {1'b0, ibit, frac};

endmodule

`default_nettype wire

>>> hw/rtl/sqg_front.sv
`default_nettype none

// Classify incoming windows and hold them in a two-word queue
module sqg_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sqg_pkg::cfg_t       cfg,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [16:0]         clip_ratio,
  input  wire logic signed [15:0]  snr_db,
  input  wire logic [16:0]         flatness,
  input  wire logic [14:0]         loss_percent,
  input  wire logic [15:0]         jitter,
  input  wire logic signed [15:0]  level_dbfs,
  input  wire logic [16:0]         silence_fraction,
  input  wire logic                q_pop,
  output logic                     q_empty,
  output sqg_pkg::win_t            q_head
);

  import sqg_pkg::*;

  win_t              cls;
  win_t              slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push_ok;
  logic              pop_ok;
  logic signed [16:0] lvl_diff;
  logic signed [16:0] snr_ext;
  logic signed [16:0] min_snr_ext;

  always_comb begin
    snr_ext     = {snr_db[15], snr_db};
    min_snr_ext = {2'b00, cfg.min_snr};
    lvl_diff    = LEVEL_KNEE - {level_dbfs[15], level_dbfs};

    cls.clip_num = clip_ratio;
    cls.snr_num  = snr_db[15] ? 17'd0 : {1'b0, snr_db};
    cls.flat_num = (flatness > FLAT_OFFSET) ? flatness - FLAT_OFFSET : 17'd0;
    cls.loss_num = loss_percent;
    cls.jit_num  = jitter;
    // half a point per dB below the knee, capped
    if (lvl_diff <= 17'sd0) begin
      cls.level_pen = '0;
    end else if (lvl_diff >= $signed(LEVEL_DIFF_SAT)) begin
      cls.level_pen = LEVEL_PEN_MAX;
    end else begin
      cls.level_pen = {lvl_diff[13:0], 7'b0};
    end
    cls.gate_ok = (silence_fraction <= cfg.max_silence)
               && (clip_ratio <= cfg.max_clipping)
               && (snr_ext >= min_snr_ext);
  end

  assign full    = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign push_ok = push && !full;
  assign pop_ok  = q_pop && !q_empty;
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 2'd1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= cls;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sqg_back.sv
`default_nettype none

// Score one window at a time, apply hysteresis, hold the result word
module sqg_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sqg_pkg::cfg_t  cfg,
  input  wire logic           q_empty,
  input  wire sqg_pkg::win_t  q_head,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic [14:0]         quality_score,
  output logic                window_passes,
  output logic                ready_res
);

  import sqg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        start;
  logic [16:0] mc_den;
  logic [16:0] ms_den;
  logic [17:0] q_clip, q_snr, q_flat, q_loss, q_jit;
  logic        b_clip, b_snr;
  logic        all_done;
  logic [15:0] flat_lo;
  logic [10:0] loss_lo;
  logic [9:0]  jit_lo;
  logic [46:0] flat_prod;
  logic [29:0] loss_prod;
  logic [29:0] jit_prod;

  logic [20:0] level_pen;
  logic        gate_ok;
  logic [16:0] c_frac, f_frac, ff, lf, jf;
  logic [20:0] c30;
  logic [22:0] s0;
  logic [17:0] mfac;
  logic [22:0] s0_r;
  logic [17:0] mfac_r;
  logic [16:0] ff_r, lf_r, jf_r;
  logic [40:0] prod_r;
  logic [22:0] s1;
  logic [22:0] sub;
  logic signed [24:0] s2;
  logic [22:0] s_clamp;
  logic [23:0] s_round;
  logic [14:0] score;
  logic [14:0] score_r;
  logic        pass_r;

  logic                      out_valid;
  logic [RUN_COUNT_BITS-1:0] pass_run, pass_run_next;
  logic [RUN_COUNT_BITS-1:0] fail_run, fail_run_next;
  logic                      ready_flag, ready_flag_next;

  function automatic logic [16:0] clamp_one(input logic [17:0] q);
    clamp_one = (q > {1'b0, FRAC_ONE}) ? FRAC_ONE : q[16:0];
  endfunction

  assign start  = (state == S_IDLE) && !q_empty;
  assign q_pop  = start;
  assign mc_den = (cfg.max_clipping == 17'd0) ? 17'd1 : cfg.max_clipping;
  assign ms_den = (cfg.min_snr == 15'd0) ? 17'd1 : {2'b00, cfg.min_snr};

  sqg_div u_div_clip (.clk, .rst, .start, .num(q_head.clip_num), .den(mc_den),
                      .busy(b_clip), .quot(q_clip));
  sqg_div u_div_snr  (.clk, .rst, .start, .num(q_head.snr_num), .den(ms_den),
                      .busy(b_snr), .quot(q_snr));

  assign all_done = !(b_clip || b_snr);

  // constant spans: reciprocal multiply, valid only below the span
  always_comb begin
    flat_lo   = q_head.flat_num[15:0];
    loss_lo   = q_head.loss_num[10:0];
    jit_lo    = q_head.jit_num[9:0];
    flat_prod = flat_lo * FLAT_RECIP;
    loss_prod = loss_lo * LOSS_RECIP;
    jit_prod  = jit_lo * JIT_RECIP;
  end

  always_comb begin
    c_frac = clamp_one(q_clip);
    f_frac = (q_snr > {1'b0, SNR_FRAC_MAX}) ? SNR_FRAC_MAX : q_snr[16:0];
    ff     = clamp_one(q_flat);
    lf     = clamp_one(q_loss);
    jf     = clamp_one(q_jit);
    c30    = {c_frac, 4'b0} + {c_frac, 4'b0} - {3'b000, c_frac, 1'b0};
    s0     = SCORE_FULL - {2'b00, c30};
    mfac   = {1'b0, FRAC_ONE} + {1'b0, f_frac};
  end

  always_comb begin
    s1  = prod_r[39:17];
    sub = {2'b00, ff_r, 4'b0} - {6'b0, ff_r}
        + {3'b000, lf_r, 3'b0} + {5'b0, lf_r, 1'b0}
        + {3'b000, jf_r, 3'b0} + {5'b0, jf_r, 1'b0}
        + {2'b00, level_pen};
    s2  = $signed({2'b00, s1}) - $signed({2'b00, sub});
    if (s2 < 25'sd0) begin
      s_clamp = '0;
    end else if (s2 > $signed({2'b00, SCORE_FULL})) begin
      s_clamp = SCORE_FULL;
    end else begin
      s_clamp = s2[22:0];
    end
    // round to nearest Q7.8
    s_round = {1'b0, s_clamp} + 24'd128;
    score   = s_round[22:8];
  end

  always_comb begin
    if (pass_r) begin
      pass_run_next = (pass_run == RUN_MAX) ? pass_run : pass_run + 1'b1;
      fail_run_next = '0;
      ready_flag_next = ready_flag
        || (RUN_CMP_BITS'(pass_run_next) >= RUN_CMP_BITS'(cfg.ok_windows_needed));
    end else begin
      pass_run_next = '0;
      fail_run_next = (fail_run == RUN_MAX) ? fail_run : fail_run + 1'b1;
      ready_flag_next = ready_flag
        && !(RUN_CMP_BITS'(fail_run_next) >= RUN_CMP_BITS'(cfg.bad_windows_needed));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_DIV;
      S_DIV:  if (all_done) state_next = S_MUL;
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_FIN;
      S_FIN:  if (!out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pass_run   <= '0;
      fail_run   <= '0;
      ready_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && !out_valid) begin
        out_valid  <= 1'b1;
        pass_run   <= pass_run_next;
        fail_run   <= fail_run_next;
        ready_flag <= ready_flag_next;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      level_pen <= q_head.level_pen;
      gate_ok   <= q_head.gate_ok;
      q_flat    <= (q_head.flat_num >= FLAT_SPAN) ? {1'b0, FRAC_ONE}
                                                  : {1'b0, flat_prod[46:30]};
      q_loss    <= ({2'b00, q_head.loss_num} >= LOSS_SPAN) ? {1'b0, FRAC_ONE}
                                                           : {1'b0, loss_prod[29:13]};
      q_jit     <= ({1'b0, q_head.jit_num} >= JIT_SPAN) ? {1'b0, FRAC_ONE}
                                                        : {1'b0, jit_prod[29:13]};
    end
    if (state == S_DIV && all_done) begin
      s0_r   <= s0;
      mfac_r <= mfac;
      ff_r   <= ff;
      lf_r   <= lf;
      jf_r   <= jf;
    end
    if (state == S_MUL) begin
      prod_r <= s0_r * mfac_r;
    end
    if (state == S_SUM) begin
      score_r <= score;
      pass_r  <= gate_ok && (score >= cfg.ready_score_threshold);
    end
    if (state == S_FIN && !out_valid) begin
      quality_score <= score_r;
      window_passes <= pass_r;
      ready_res     <= ready_flag_next;
    end
  end

  assign empty = !out_valid;

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quality_score <= SCORE_MAX)
    else $error("quality score above 100");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(pass_run != '0 && fail_run != '0))
    else $error("pass and fail runs both nonzero");

  a_fin_writes: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("finished word not written");

  a_ready_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(ready_flag) |-> (out_valid && window_passes && ready_res))
    else $error("ready rose without a passing word");

endmodule

`default_nettype wire

>>> hw/rtl/speech_quality_gate_hysteresis.sv
`default_nettype none

// Channel   Handshake        Payload
// input     push / full      clip_ratio, snr_db, flatness, loss_percent, jitter,
//                            level_dbfs, silence_fraction
// result    empty / pop      quality_score, window_passes, ready_res
// config    wr_en            wr_index, wr_data
//
// A window's time from accept to result is set by the two 16-step
// dividers (clipping, SNR) that run side by side; when both quotients reach 2.0
// they finish at once. The back end scores one window at a time.
// The front end classifies on accept and queues up to two words, so input is
// taken while a result waits; a stalled result holds the back end at its end.
// rst is synchronous; it clears the queues, run counters and ready flag and
// loads the register defaults.
module speech_quality_gate_hysteresis (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [16:0]        clip_ratio,
  input  wire logic signed [15:0] snr_db,
  input  wire logic [16:0]        flatness,
  input  wire logic [14:0]        loss_percent,
  input  wire logic [15:0]        jitter,
  input  wire logic signed [15:0] level_dbfs,
  input  wire logic [16:0]        silence_fraction,
  output logic                    empty,
  input  wire logic               pop,
  output logic [14:0]             quality_score,
  output logic                    window_passes,
  output logic                    ready_res,
  input  wire logic               wr_en,
  input  wire logic [2:0]         wr_index,
  input  wire logic [16:0]        wr_data
);

  import sqg_pkg::*;

  cfg_t cfg;
  logic q_pop;
  logic q_empty;
  win_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_clipping          <= 17'd655;
      cfg.min_snr               <= 15'd3840;
      cfg.ready_score_threshold <= 15'd15360;
      cfg.max_silence           <= 17'd52429;
      cfg.ok_windows_needed     <= WIN_COUNT_BITS'(3);
      cfg.bad_windows_needed    <= WIN_COUNT_BITS'(3);
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_CLIPPING: cfg.max_clipping          <= wr_data;
        REG_MIN_SNR:      cfg.min_snr               <= wr_data[14:0];
        REG_SCORE_THR:    cfg.ready_score_threshold <= wr_data[14:0];
        REG_MAX_SILENCE:  cfg.max_silence           <= wr_data;
        REG_OK_WINDOWS:   cfg.ok_windows_needed     <= wr_data[WIN_COUNT_BITS-1:0];
        REG_BAD_WINDOWS:  cfg.bad_windows_needed    <= wr_data[WIN_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  sqg_front u_front (
    .clk, .rst, .cfg, .push, .full,
    .clip_ratio, .snr_db, .flatness, .loss_percent, .jitter, .level_dbfs,
    .silence_fraction,
    .q_pop, .q_empty, .q_head
  );

  sqg_back u_back (
    .clk, .rst, .cfg, .q_empty, .q_head, .q_pop,
    .empty, .pop, .quality_score, .window_passes, .ready_res
  );

endmodule

`default_nettype wire

>>> sim/tb_speech_quality_gate_hysteresis.sv
`timescale 1ns / 100ps

module tb_speech_quality_gate_hysteresis;
  import sqg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RUN_MAX = (1 << RUN_COUNT_BITS) - 1;
  localparam longint ONE = 65536;
  // Indexes past the register list; writes there must change nothing
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [16:0] clip;
    logic [15:0] snr;
    logic [16:0] flat;
    logic [14:0] loss;
    logic [15:0] jit;
    logic [15:0] lvl;
    logic [16:0] sil;
  } window_t;

  typedef struct packed {
    logic [14:0] score;
    logic        passes;
    logic        ready;
  } verdict_t;

  typedef struct packed {
    window_t  win;
    logic     typed;
    verdict_t want;
  } dir_row_t;

  typedef struct packed {
    logic [16:0] max_clip;
    logic [14:0] min_snr;
    logic [14:0] score_thr;
    logic [16:0] max_sil;
    logic [7:0]  ok_need;
    logic [7:0]  bad_need;
    logic [15:0] items;
    logic [15:0] run_lo;
    logic [15:0] run_hi;
    logic        long_runs;
  } phase_t;

  typedef enum {W_GOOD, W_BAD, W_NOISE} shape_t;
  typedef enum {F_CLIP, F_SNR, F_SILENCE, F_NETWORK, F_LEVEL, F_FLAT} fault_t;

  // Defaults after reset: perfect windows raise ready on the third, worst windows
  // drop it on the third; two more rows carry typed results, the rest walks field boundaries and is predicted.
  localparam dir_row_t DIRECTED [22] = '{
    '{'{0, 32767, 0, 0, 0, 0, 0}, 1, '{25600, 1, 0}},
    '{'{0, 32767, 0, 0, 0, 0, 0}, 1, '{25600, 1, 0}},
    '{'{0, 32767, 0, 0, 0, 0, 0}, 1, '{25600, 1, 1}},
    '{'{65536, -32768, 65536, 25600, 65535, -32768, 65536}, 1, '{0, 0, 1}},
    '{'{65536, -32768, 65536, 25600, 65535, -32768, 65536}, 1, '{0, 0, 1}},
    '{'{65536, -32768, 65536, 25600, 65535, -32768, 65536}, 1, '{0, 0, 0}},
    '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{12800, 0, 0}},
    '{'{0, 3840, 0, 0, 0, 0, 0}, 1, '{25600, 1, 0}},
    '{'{655, 32767, 0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{'{656, 32767, 0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{'{0, 32767, 19661, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{'{0, 32767, 19662, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{'{0, 32767, 131071, 32767, 65535, 0, 0}, 0, '{0, 0, 0}},
    '{'{0, 32767, 0, 0, 0, -12800, 0}, 0, '{0, 0, 0}},
    '{'{0, 32767, 0, 0, 0, -12801, 0}, 0, '{0, 0, 0}},
    '{'{0, 32767, 0, 0, 0, 32767, 0}, 0, '{0, 0, 0}},
    '{'{0, 32767, 0, 0, 0, 0, 52429}, 0, '{0, 0, 0}},
    '{'{0, 32767, 0, 0, 0, 0, 52430}, 0, '{0, 0, 0}},
    '{'{131071, -1, 0, 0, 0, -1, 131071}, 0, '{0, 0, 0}},
    '{'{0, 1, 0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{'{100, 5000, 30000, 1280, 800, -20000, 1000}, 0, '{0, 0, 0}},
    '{'{0, 32767, 0, 1, 1, 0, 0}, 0, '{0, 0, 0}}
  };

  // Register settings per phase, then item count, run length range, long-run mode
  localparam phase_t PHASES [5] = '{
    '{0, 0, 0, 65536, 0, 0, 140, 1, 8, 0},
    '{65536, 32767, 25600, 0, 255, 255, 140, 1, 8, 0},
    '{1, 1, 12800, 131071, 1, 2, 140, 1, 8, 0},
    '{655, 3840, 15360, 52429, 3, 3, 140, 1, 8, 0},
    '{65536, 1, 0, 65536, 255, 255, 540, 256, 280, 1}
  };

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [16:0] clip_ratio = '0;
  logic signed [15:0] snr_db = '0;
  logic [16:0] flatness = '0;
  logic [14:0] loss_percent = '0;
  logic [15:0] jitter = '0;
  logic signed [15:0] level_dbfs = '0;
  logic [16:0] silence_fraction = '0;
  logic empty;
  logic pop = 1'b0;
  logic [14:0] quality_score;
  logic window_passes;
  logic ready_res;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = REG_MAX_CLIPPING;
  logic [16:0] wr_data = '0;

  speech_quality_gate_hysteresis dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .clip_ratio(clip_ratio), .snr_db(snr_db), .flatness(flatness),
    .loss_percent(loss_percent), .jitter(jitter), .level_dbfs(level_dbfs),
    .silence_fraction(silence_fraction),
    .empty(empty), .pop(pop),
    .quality_score(quality_score), .window_passes(window_passes),
    .ready_res(ready_res),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Gate model state
  cfg_t gate_cfg;
  int pass_streak = 0;
  int fail_streak = 0;
  bit ready_now = 0;

  verdict_t verdicts_due[$];
  int mismatches = 0;
  int windows_sent = 0;
  int results_checked = 0;
  int windows_passed = 0;
  int ready_rises = 0;
  int ready_falls = 0;
  int streak_saturations = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic longint ratio_q16(longint num, longint den);
    longint q;
    if (num <= 0) return 0;
    q = num * ONE / den;
    return (q > ONE) ? ONE : q;
  endfunction

  // Score one window and advance the hysteresis state
  function automatic verdict_t grade_window(window_t w);
    longint clip, snr, flat, loss, jit, lvl, sil;
    longint clip_lim, snr_min, thr, sil_max, div_clip, div_snr;
    longint f, s, pen, score;
    bit ok;
    verdict_t v;
    clip = w.clip;
    snr = $signed(w.snr);
    flat = w.flat;
    loss = w.loss;
    jit = w.jit;
    lvl = $signed(w.lvl);
    sil = w.sil;
    clip_lim = gate_cfg.max_clipping;
    snr_min = gate_cfg.min_snr;
    thr = gate_cfg.ready_score_threshold;
    sil_max = gate_cfg.max_silence;
    div_clip = (clip_lim == 0) ? 1 : clip_lim;
    div_snr = (snr_min == 0) ? 1 : snr_min;

    s = 100 * ONE - 30 * ratio_q16(clip, div_clip);
    if (snr <= 0) f = 0;
    else begin
      f = snr * ONE / div_snr;
      if (f > 98304) f = 98304;
    end
    s = (s * (ONE + f)) >>> 17;
    s -= 15 * ratio_q16(flat - 19661, 45875);
    s -= 10 * ratio_q16(loss, 1280);
    s -= 10 * ratio_q16(jit, 800);
    if (lvl < -12800) begin
      pen = (-12800 - lvl) * 128;
      if (pen > 20 * ONE) pen = 20 * ONE;
      s -= pen;
    end
    if (s < 0) s = 0;
    if (s > 100 * ONE) s = 100 * ONE;
    score = (s + 128) >>> 8;

    ok = score >= thr && sil <= sil_max && clip <= clip_lim && snr >= snr_min;
    if (ok) begin
      windows_passed++;
      if (pass_streak < RUN_MAX) pass_streak++;
      else streak_saturations++;
      fail_streak = 0;
      if (!ready_now && pass_streak >= int'(gate_cfg.ok_windows_needed)) begin
        ready_now = 1;
        ready_rises++;
      end
    end else begin
      if (fail_streak < RUN_MAX) fail_streak++;
      else streak_saturations++;
      pass_streak = 0;
      if (ready_now && fail_streak >= int'(gate_cfg.bad_windows_needed)) begin
        ready_now = 0;
        ready_falls++;
      end
    end
    v.score = 15'(score);
    v.passes = ok;
    v.ready = ready_now;
    return v;
  endfunction

  function automatic window_t draw_window(shape_t shape, bit snr_only);
    window_t w;
    fault_t fault;
    if (shape == W_NOISE) begin
      w.clip = 17'($urandom);
      w.snr = 16'($urandom);
      w.flat = 17'($urandom);
      w.loss = 15'($urandom);
      w.jit = 16'($urandom);
      w.lvl = 16'($urandom);
      w.sil = 17'($urandom);
      return w;
    end
    w.clip = ($urandom_range(0, 3) == 0) ? 17'd0 : 17'($urandom_range(0, 300));
    w.snr = ($urandom_range(0, 3) == 0) ? 16'd32767 : 16'($urandom_range(3840, 32767));
    w.flat = ($urandom_range(0, 2) == 0) ? 17'd0 : 17'($urandom_range(0, 30000));
    w.loss = ($urandom_range(0, 2) == 0) ? 15'd0 : 15'($urandom_range(0, 200));
    w.jit = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 120));
    w.lvl = 16'(-int'($urandom_range(0, 14000)));
    w.sil = ($urandom_range(0, 3) == 0) ? 17'd0 : 17'($urandom_range(0, 45000));
    if (shape == W_BAD) begin
      fault = snr_only ? F_SNR : fault_t'($urandom_range(0, 5));
      case (fault)
        F_CLIP: w.clip = 17'($urandom_range(700, 65536));
        F_SNR: w.snr = 16'(-int'($urandom_range(0, 32768)));
        F_SILENCE: w.sil = 17'($urandom_range(52430, 65536));
        F_NETWORK: begin
          w.loss = 15'($urandom_range(1280, 25600));
          w.jit = 16'($urandom_range(800, 65535));
        end
        F_LEVEL: w.lvl = 16'(-int'($urandom_range(12801, 32768)));
        default: w.flat = 17'($urandom_range(40000, 65536));
      endcase
    end
    return w;
  endfunction

  // Offer one word after a random gap, or none when steady; log its expected result on accept
  task automatic push_window(window_t w, bit steady, bit typed, verdict_t want);
    int gap;
    verdict_t v;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    clip_ratio = w.clip;
    snr_db = w.snr;
    flatness = w.flat;
    loss_percent = w.loss;
    jitter = w.jit;
    level_dbfs = w.lvl;
    silence_fraction = w.sil;
    push = 1'b1;
    do @(posedge clk); while (full);
    v = grade_window(w);
    verdicts_due.push_back(typed ? want : v);
    windows_sent++;
  endtask

  // Hold off input until every outstanding result has drained
  task automatic wait_idle();
    @(negedge clk);
    push = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      REG_MAX_CLIPPING: gate_cfg.max_clipping = val;
      REG_MIN_SNR:      gate_cfg.min_snr = val[14:0];
      REG_SCORE_THR:    gate_cfg.ready_score_threshold = val[14:0];
      REG_MAX_SILENCE:  gate_cfg.max_silence = val;
      REG_OK_WINDOWS:   gate_cfg.ok_windows_needed = val[7:0];
      REG_BAD_WINDOWS:  gate_cfg.bad_windows_needed = val[7:0];
      default: ;
    endcase
  endtask

  task automatic check_result();
    verdict_t want;
    results_checked++;
    if (verdicts_due.size() == 0) begin
      flag_mismatch("result with nothing outstanding", quality_score, -1);
      return;
    end
    want = verdicts_due.pop_front();
    if (quality_score !== want.score) flag_mismatch("quality_score", quality_score, want.score);
    if (window_passes !== want.passes)
      flag_mismatch("window_passes", window_passes, want.passes);
    if (ready_res !== want.ready) flag_mismatch("ready_res", ready_res, want.ready);
  endtask

  // Result side: random stall per word, with stretches of back-to-back pops
  initial begin
    int stall;
    int left_in_stretch;
    bit steady;
    left_in_stretch = 0;
    steady = 0;
    while (rst) @(negedge clk);
    forever begin
      if (left_in_stretch == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        left_in_stretch = 16;
      end
      left_in_stretch--;
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        @(negedge clk);
        pop = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      pop = 1'b1;
      do @(posedge clk); while (empty);
      check_result();
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int left;
    int len;
    int roll;
    shape_t shape;
    bit steady;
    bit pass_turn;
    verdict_t none;
    none = '0;
    gate_cfg.max_clipping = 17'd655;
    gate_cfg.min_snr = 15'd3840;
    gate_cfg.ready_score_threshold = 15'd15360;
    gate_cfg.max_silence = 17'd52429;
    gate_cfg.ok_windows_needed = 8'd3;
    gate_cfg.bad_windows_needed = 8'd3;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i])
      push_window(DIRECTED[i].win, 1'b0, DIRECTED[i].typed, DIRECTED[i].want);

    foreach (PHASES[p]) begin
      wait_idle();
      write_reg(REG_MAX_CLIPPING, PHASES[p].max_clip);
      write_reg(REG_MIN_SNR, 17'(PHASES[p].min_snr));
      write_reg(REG_SCORE_THR, 17'(PHASES[p].score_thr));
      write_reg(REG_MAX_SILENCE, PHASES[p].max_sil);
      write_reg(REG_OK_WINDOWS, 17'(PHASES[p].ok_need));
      write_reg(REG_BAD_WINDOWS, 17'(PHASES[p].bad_need));
      if (p == 0) begin
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, '1);
      end
      left = PHASES[p].items;
      pass_turn = 1;
      while (left > 0) begin
        len = $urandom_range(PHASES[p].run_lo, PHASES[p].run_hi);
        if (len > left) len = left;
        // Long-run mode alternates clean passes and SNR failures to saturate both counters
        if (PHASES[p].long_runs) begin
          shape = pass_turn ? W_GOOD : W_BAD;
          pass_turn = !pass_turn;
        end else begin
          roll = $urandom_range(0, 99);
          shape = (roll < 45) ? W_GOOD : ((roll < 75) ? W_BAD : W_NOISE);
        end
        steady = ($urandom_range(0, 4) == 0);
        repeat (len) push_window(draw_window(shape, PHASES[p].long_runs), steady, 1'b0, none);
        left -= len;
      end
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (verdicts_due.size() != 0)
      flag_mismatch("results never delivered", 0, verdicts_due.size());

    $display("%0d windows over %0d register settings, %0d results checked, %0d mismatches",
             windows_sent, $size(PHASES) + 1, results_checked, mismatches);
    $display("%0d windows passed, ready rose %0d and fell %0d times, %0d saturated counts",
             windows_passed, ready_rises, ready_falls, streak_saturations);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
